/* hdl/assert_macros.svh */
// assertion macros for the transmit buffer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define UTB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utb check failed");

// consequent must hold in the cycle after the antecedent
`define UTB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utb check failed");

`endif

/* hdl/utb_pkg.sv */
// types, codes and defaults of the uart transmit ring buffer
`timescale 1ns / 1ps
`default_nettype none

package utb_pkg;

  localparam int BUF_DEPTH_DEF = 64;
  localparam int BURST_MAX_DEF = 16;
  localparam int LEVEL_W       = 7;

  typedef logic [1:0]         kind_t;
  typedef logic [LEVEL_W-1:0] level_t;

  localparam logic  CMD_PUT   = 1'b0;
  localparam logic  CMD_DRAIN = 1'b1;

  localparam kind_t KIND_SENT   = 2'd0;
  localparam kind_t KIND_NONE   = 2'd1;
  localparam kind_t KIND_REJECT = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
    logic       tx_ready;
  } in_word_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       last;
    level_t     level;
  } out_word_t;

  // controller to output stage
  typedef struct packed {
    logic   issue;
    logic   last;
    level_t level;
    logic   st_valid;
    kind_t  st_kind;
    level_t st_level;
  } ctrl_req_t;

  // output stage to controller
  typedef struct packed {
    logic can_issue;
    logic st_taken;
  } ctrl_rsp_t;

endpackage

`default_nettype wire

/* hdl/utb_stream_if.sv */
// valid/ready channel carrying one word of a given payload type
`timescale 1ns / 1ps
`default_nettype none

interface utb_stream_if #(parameter type payload_t = logic);

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

`default_nettype wire

/* hdl/utb_ram.sv */
// generic single write port, single read port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module utb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* hdl/utb_ctrl.sv */
// sequencer: ring indices, fill count, burst reads and deferred store
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module utb_ctrl #(
  parameter int BUF_DEPTH = utb_pkg::BUF_DEPTH_DEF,
  parameter int BURST_MAX = utb_pkg::BURST_MAX_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  utb_stream_if.sink                   in_ch,
  output utb_pkg::ctrl_req_t           req,
  input  utb_pkg::ctrl_rsp_t           rsp,
  output logic                         wr_en,
  output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
  output logic [7:0]                   wr_data,
  output logic                         rd_en,
  output logic [$clog2(BUF_DEPTH)-1:0] rd_addr
);

  import utb_pkg::*;

  localparam int IW = $clog2(BUF_DEPTH);
  localparam int FW = $clog2(BUF_DEPTH + 1);
  localparam int CW = $clog2(BURST_MAX + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_BURST  = 2'd1;
  localparam logic [1:0] ST_STORE  = 2'd2;
  localparam logic [1:0] ST_STATUS = 2'd3;

  logic [1:0]    state, state_next;
  logic [IW-1:0] rd_idx, rd_idx_next;
  logic [IW-1:0] wr_idx, wr_idx_next;
  logic [FW-1:0] fill, fill_next;
  logic [CW-1:0] cnt, cnt_next;
  logic          defer, defer_next;
  logic [7:0]    held, held_next;
  kind_t         st_kind, st_kind_next;

  logic          full;
  logic          last_byte;
  logic [FW-1:0] fill_inc;
  logic [FW-1:0] fill_dec;

  function automatic logic [IW-1:0] idx_inc(input logic [IW-1:0] idx);
    idx_inc = (idx == IW'(BUF_DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  // bytes in one burst: min(count, BURST_MAX)
  function automatic logic [CW-1:0] burst_len(input logic [FW-1:0] f);
    burst_len = (32'(f) >= BURST_MAX) ? CW'(BURST_MAX) : CW'(f);
  endfunction

  assign full      = (fill == FW'(BUF_DEPTH));
  assign last_byte = (cnt == CW'(1));
  assign fill_inc  = fill + 1'b1;
  assign fill_dec  = fill - 1'b1;

  assign in_ch.ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    rd_idx_next  = rd_idx;
    wr_idx_next  = wr_idx;
    fill_next    = fill;
    cnt_next     = cnt;
    defer_next   = defer;
    held_next    = held;
    st_kind_next = st_kind;
    wr_en        = 1'b0;
    wr_data      = in_ch.data.data_byte;
    rd_en        = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.data.cmd == CMD_PUT) begin
            if (full) begin
              if (!in_ch.data.tx_ready) begin
                st_kind_next = KIND_REJECT;
                state_next   = ST_STATUS;
              end else begin
                // burst first, byte goes in once the burst has ended
                cnt_next   = burst_len(fill);
                defer_next = 1'b1;
                held_next  = in_ch.data.data_byte;
                state_next = ST_BURST;
              end
            end else begin
              wr_en       = 1'b1;
              wr_idx_next = idx_inc(wr_idx);
              fill_next   = fill_inc;
              if (in_ch.data.tx_ready) begin
                cnt_next   = burst_len(fill_inc);
                defer_next = 1'b0;
                state_next = ST_BURST;
              end else begin
                st_kind_next = KIND_NONE;
                state_next   = ST_STATUS;
              end
            end
          end else if (in_ch.data.tx_ready && fill != '0) begin
            cnt_next   = burst_len(fill);
            defer_next = 1'b0;
            state_next = ST_BURST;
          end else begin
            st_kind_next = KIND_NONE;
            state_next   = ST_STATUS;
          end
        end
      end
      ST_BURST: begin
        if (rsp.can_issue) begin
          rd_en       = 1'b1;
          rd_idx_next = idx_inc(rd_idx);
          fill_next   = fill_dec;
          cnt_next    = cnt - 1'b1;
          if (last_byte) begin
            state_next = defer ? ST_STORE : ST_IDLE;
          end
        end
      end
      ST_STORE: begin
        wr_en       = 1'b1;
        wr_data     = held;
        wr_idx_next = idx_inc(wr_idx);
        fill_next   = fill_inc;
        state_next  = ST_IDLE;
      end
      ST_STATUS: begin
        if (rsp.st_taken) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign wr_addr = wr_idx;
  assign rd_addr = rd_idx;

  always_comb begin
    req.issue    = rd_en;
    req.last     = last_byte;
    // final byte of a full-buffer put already counts the deferred byte
    req.level    = (defer && last_byte) ? level_t'(fill) : level_t'(fill_dec);
    req.st_valid = (state == ST_STATUS);
    req.st_kind  = st_kind;
    req.st_level = level_t'(fill);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_idx <= '0;
      wr_idx <= '0;
      fill   <= '0;
      cnt    <= '0;
      defer  <= 1'b0;
    end else begin
      state  <= state_next;
      rd_idx <= rd_idx_next;
      wr_idx <= wr_idx_next;
      fill   <= fill_next;
      cnt    <= cnt_next;
      defer  <= defer_next;
    end
  end

  always_ff @(posedge clk) begin
    held    <= held_next;
    st_kind <= st_kind_next;
  end

  `UTB_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FW'(BUF_DEPTH))
  `UTB_ASSERT_NOW(a_burst_count, state == ST_BURST, cnt != '0)
  `UTB_ASSERT_NOW(a_read_in_burst, rd_en, state == ST_BURST && rsp.can_issue)
  `UTB_ASSERT_NEXT(a_burst_ends, rd_en && last_byte, state != ST_BURST)
  `UTB_ASSERT_NOW(a_store_full_ptrs, state == ST_STORE, fill != FW'(BUF_DEPTH))

endmodule

`default_nettype wire

/* hdl/utb_out_stage.sv */
// read-data stage and output register of the transmit buffer
`timescale 1ns / 1ps
`default_nettype none

module utb_out_stage (
  input  logic               clk,
  input  logic               rst,
  input  utb_pkg::ctrl_req_t req,
  output utb_pkg::ctrl_rsp_t rsp,
  input  logic [7:0]         rd_data,
  utb_stream_if.source       out_ch
);

  import utb_pkg::*;

  logic      pend_valid;
  logic      pend_last;
  level_t    pend_level;
  logic      out_valid;
  out_word_t out_word;

  logic out_free;
  logic load_pend;
  logic load_st;

  assign out_free  = !out_valid || out_ch.ready;
  assign load_pend = pend_valid && out_free;
  // status word waits until every byte read earlier has moved on
  assign load_st   = req.st_valid && !pend_valid && out_free;

  always_comb begin
    rsp.can_issue = !pend_valid || load_pend;
    rsp.st_taken  = load_st;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (req.issue) begin
        pend_valid <= 1'b1;
      end else if (load_pend) begin
        pend_valid <= 1'b0;
      end
      if (load_pend || load_st) begin
        out_valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.issue) begin
      pend_last  <= req.last;
      pend_level <= req.level;
    end
    if (load_pend) begin
      out_word <= '{kind: KIND_SENT, tx_byte: rd_data, last: pend_last, level: pend_level};
    end else if (load_st) begin
      out_word <= '{kind: req.st_kind, tx_byte: 8'h00, last: 1'b1, level: req.st_level};
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data  = out_word;

endmodule

`default_nettype wire

/* hdl/uart_tx_ring_buffer_burst_drain_core.sv */
// top level of the uart transmit ring buffer with burst drain
//
//   channel  dir  payload                          handshake
//   in_ch    in   cmd, data_byte, tx_ready         valid/ready
//   out_ch   out  kind, tx_byte, last, level       valid/ready
//
// an item is taken while idle; with tx_ready set, a burst of min(count,
// BURST_MAX) bytes then goes out one per cycle while the output accepts;
// a put into a full buffer writes its byte after it, and items wait meanwhile
// the single ram read port sets the one-byte-per-cycle pace of an unstalled burst
// status words (nothing sent, rejected) need a free output, no pending byte
// reset clears indices and count; the byte store needs no clearing
// a stalled output holds the read stage, which stops further reads
`timescale 1ns / 1ps
`default_nettype none

module uart_tx_ring_buffer_burst_drain_core #(
  parameter int BUF_DEPTH = utb_pkg::BUF_DEPTH_DEF,
  parameter int BURST_MAX = utb_pkg::BURST_MAX_DEF
) (
  input logic          clk,
  input logic          rst,
  utb_stream_if.sink   in_ch,
  utb_stream_if.source out_ch
);

  import utb_pkg::*;

  localparam int IW = $clog2(BUF_DEPTH);

  ctrl_req_t     req;
  ctrl_rsp_t     rsp;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic [7:0]    rd_data;

  utb_ctrl #(
    .BUF_DEPTH (BUF_DEPTH),
    .BURST_MAX (BURST_MAX)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .req     (req),
    .rsp     (rsp),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr)
  );

  utb_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_byte_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  utb_out_stage u_out (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rsp     (rsp),
    .rd_data (rd_data),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
